// ----- hdl/bfwdp_pkg.sv -----
// shared types, widths and defaults for the bounded fifo with drop policy
`default_nettype none
package bfwdp_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int DATA_W = 32;
	localparam int CNT_W = 4;
	localparam int LIMIT_W = 4;
	localparam int CFG_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int OUT_TDATA_W = 136;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLOSE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_DROPPED = 2'd1,
		ST_STALL   = 2'd2,
		ST_CLOSED  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUEUE_LIMIT = 1'd0,
		REG_BLOCK_MODE  = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} mem_ctl_t;

	function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
		return (v == {DATA_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bfwdp_store.sv -----
// entry memory: one write port, one read port with registered read data
`default_nettype none
module bfwdp_store #(
	parameter int DEPTH = bfwdp_pkg::DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire bfwdp_pkg::mem_ctl_t           ctl,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [bfwdp_pkg::DATA_W-1:0]  wr_data,
	input  wire logic [AW-1:0]                 rd_addr,
	output logic      [bfwdp_pkg::DATA_W-1:0]  rd_data
);

	logic [bfwdp_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/bfwdp_ctrl.sv -----
// queue control: pointers, open flag, counters, policy and result register
`default_nettype none
module bfwdp_ctrl #(
	parameter int DEPTH = bfwdp_pkg::DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [bfwdp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bfwdp_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       in_op,
	input  wire logic [bfwdp_pkg::DATA_W-1:0]     in_value,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [1:0]                       out_status,
	output logic                                  out_popped,
	output logic      [bfwdp_pkg::CNT_W-1:0]      out_occupancy,
	output logic      [bfwdp_pkg::DATA_W-1:0]     out_produced,
	output logic      [bfwdp_pkg::DATA_W-1:0]     out_consumed,
	output logic      [bfwdp_pkg::DATA_W-1:0]     out_dropped,
	output bfwdp_pkg::mem_ctl_t                   mem_ctl,
	output logic      [AW-1:0]                    mem_wr_addr,
	output logic      [bfwdp_pkg::DATA_W-1:0]     mem_wr_data,
	output logic      [AW-1:0]                    mem_rd_addr
);

	localparam int SW = ((AW > bfwdp_pkg::CNT_W) ? AW : bfwdp_pkg::CNT_W) + 1;

	logic [bfwdp_pkg::LIMIT_W-1:0] limit_q;
	logic                          block_q;
	logic [AW-1:0]                 head_q;
	logic [bfwdp_pkg::CNT_W-1:0]   count_q;
	logic                          open_q;
	logic [bfwdp_pkg::DATA_W-1:0]  produced_q;
	logic [bfwdp_pkg::DATA_W-1:0]  consumed_q;
	logic [bfwdp_pkg::DATA_W-1:0]  dropped_q;
	logic                          valid_s1;
	bfwdp_pkg::status_t            status_s1;
	logic                          popped_s1;

	logic                          accept;
	logic [bfwdp_pkg::LIMIT_W-1:0] limit_n;
	logic                          full;
	logic [SW-1:0]                 tail_sum;
	logic [SW-1:0]                 tail_wrap;
	logic [AW-1:0]                 head_next;
	logic                          do_push;
	logic                          do_pop;
	logic                          do_drop;
	logic                          do_close;
	bfwdp_pkg::status_t            status_n;

	assign in_ready = !valid_s1 || out_ready;
	assign accept = in_valid && in_ready;

	assign limit_n = (limit_q == '0) ? bfwdp_pkg::LIMIT_W'(1) : limit_q;
	assign full = (count_q >= limit_n) || (32'(count_q) >= 32'(DEPTH));

	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
	assign head_next = (32'(head_q) == 32'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		do_push = 1'b0;
		do_pop = 1'b0;
		do_drop = 1'b0;
		do_close = 1'b0;
		status_n = bfwdp_pkg::ST_DONE;
		case (bfwdp_pkg::op_t'(in_op))
			bfwdp_pkg::OP_PUSH: begin
				if (block_q) begin
					if (!open_q) begin
						status_n = bfwdp_pkg::ST_CLOSED;
					end else if (full) begin
						status_n = bfwdp_pkg::ST_STALL;
					end else begin
						do_push = 1'b1;
					end
				end else if (full) begin
					status_n = bfwdp_pkg::ST_DROPPED;
					do_drop = 1'b1;
				end else begin
					do_push = 1'b1;
				end
			end
			bfwdp_pkg::OP_POP: begin
				if (count_q != '0) begin
					do_pop = 1'b1;
				end else begin
					status_n = open_q ? bfwdp_pkg::ST_STALL : bfwdp_pkg::ST_CLOSED;
				end
			end
			bfwdp_pkg::OP_CLOSE: begin
				do_close = 1'b1;
			end
			default: begin
				status_n = bfwdp_pkg::ST_DONE;
			end
		endcase
	end

	assign mem_ctl.wr = accept && do_push;
	assign mem_ctl.rd = accept && do_pop;
	assign mem_wr_addr = tail_wrap[AW-1:0];
	assign mem_wr_data = in_value;
	assign mem_rd_addr = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bfwdp_pkg::LIMIT_RESET;
			block_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (bfwdp_pkg::reg_idx_t'(cfg_index))
				bfwdp_pkg::REG_QUEUE_LIMIT: limit_q <= cfg_data[bfwdp_pkg::LIMIT_W-1:0];
				bfwdp_pkg::REG_BLOCK_MODE:  block_q <= cfg_data[0];
				default: begin
					limit_q <= limit_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			open_q <= 1'b1;
			produced_q <= '0;
			consumed_q <= '0;
			dropped_q <= '0;
			valid_s1 <= 1'b0;
			status_s1 <= bfwdp_pkg::ST_DONE;
			popped_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				status_s1 <= status_n;
				popped_s1 <= do_pop;
				if (do_push) begin
					count_q <= count_q + 1'b1;
					produced_q <= bfwdp_pkg::sat_inc(produced_q);
				end
				if (do_pop) begin
					head_q <= head_next;
					count_q <= count_q - 1'b1;
					consumed_q <= bfwdp_pkg::sat_inc(consumed_q);
				end
				if (do_drop) begin
					dropped_q <= bfwdp_pkg::sat_inc(dropped_q);
				end
				if (do_close) begin
					open_q <= 1'b0;
				end
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign out_valid = valid_s1;
	assign out_status = status_s1;
	assign out_popped = popped_s1;
	assign out_occupancy = count_q;
	assign out_produced = produced_q;
	assign out_consumed = consumed_q;
	assign out_dropped = dropped_q;

endmodule
`default_nettype wire

// ----- hdl/bounded_fifo_with_drop_policy_core.sv -----
// top level of the bounded fifo with drop policy
// The queue takes one transfer per clock: a push, a pop or a close, given in
// s_tuser, with the push word in s_tdata. Each transfer gives exactly one result
// in the next cycle, in a single output register; a new transfer is taken in the
// same cycle the previous result is taken, so the sustained rate is one item
// per clock while m_tready stays high. Entries live in a DEPTH-word memory with
// one write and one registered read port; the pop word comes straight from that
// read register. Occupancy and the three saturating counters in the result are
// the values after the item. The fill limit (register 0) is clamped to 1..DEPTH;
// register 1 selects refuse-and-stall instead of drop on a full queue.
`default_nettype none
module bounded_fifo_with_drop_policy_core #(
	parameter int DEPTH = bfwdp_pkg::DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [bfwdp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bfwdp_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// push_value
	input  wire logic [bfwdp_pkg::DATA_W-1:0]         s_tdata,
	// operation
	input  wire logic [1:0]                           s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// pop_value, occupancy, produced_count, consumed_count, dropped_count, zero pad
	output logic      [bfwdp_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// status
	output logic      [1:0]                           m_tuser
);

	localparam int AW = $clog2(DEPTH);

	bfwdp_pkg::mem_ctl_t             mem_ctl;
	logic [AW-1:0]                   mem_wr_addr;
	logic [bfwdp_pkg::DATA_W-1:0]    mem_wr_data;
	logic [AW-1:0]                   mem_rd_addr;
	logic [bfwdp_pkg::DATA_W-1:0]    mem_rd_data;
	logic                            popped;
	logic [bfwdp_pkg::CNT_W-1:0]     occupancy;
	logic [bfwdp_pkg::DATA_W-1:0]    produced_count;
	logic [bfwdp_pkg::DATA_W-1:0]    consumed_count;
	logic [bfwdp_pkg::DATA_W-1:0]    dropped_count;
	logic [bfwdp_pkg::DATA_W-1:0]    pop_value;

	bfwdp_ctrl #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_op(s_tuser),
		.in_value(s_tdata),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_status(m_tuser),
		.out_popped(popped),
		.out_occupancy(occupancy),
		.out_produced(produced_count),
		.out_consumed(consumed_count),
		.out_dropped(dropped_count),
		.mem_ctl(mem_ctl),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_addr(mem_rd_addr)
	);

	bfwdp_store #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.ctl(mem_ctl),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	assign pop_value = popped ? mem_rd_data : '0;
	assign m_tdata = {4'b0000, dropped_count, consumed_count, produced_count,
		occupancy, pop_value};

endmodule
`default_nettype wire

// ----- tb/fifo_result_checker.sv -----
// checker that predicts every result of the bounded fifo and compares it with the dut output
module fifo_result_checker
	import bfwdp_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_data,
	input  wire logic                       s_tvalid,
	input  wire logic                       s_tready,
	// push_value
	input  wire logic [DATA_W-1:0]          s_tdata,
	// operation
	input  wire logic [1:0]                 s_tuser,
	input  wire logic                       m_tvalid,
	input  wire logic                       m_tready,
	// pop_value, occupancy, produced_count, consumed_count, dropped_count, zero pad
	input  wire logic [OUT_TDATA_W-1:0]     m_tdata,
	// status
	input  wire logic [1:0]                 m_tuser,
	output int unsigned                     mismatches,
	output int unsigned                     pending
);

	localparam int DEPTH = DEPTH_DEF;
	localparam int OCC_LSB = DATA_W;
	localparam int PROD_LSB = OCC_LSB + CNT_W;
	localparam int CONS_LSB = PROD_LSB + DATA_W;
	localparam int DROP_LSB = CONS_LSB + DATA_W;
	localparam int PAD_LSB = DROP_LSB + DATA_W;
	localparam int RING_DEPTH = 4;

	typedef struct packed {
		status_t             status;
		logic [DATA_W-1:0]   pop_value;
		logic [CNT_W-1:0]    occupancy;
		logic [DATA_W-1:0]   produced;
		logic [DATA_W-1:0]   consumed;
		logic [DATA_W-1:0]   dropped;
	} queue_result_t;

	logic [DATA_W-1:0]  shadow_store [DEPTH];
	int unsigned        shadow_head;
	int unsigned        shadow_count;
	logic               shadow_open;
	logic               shadow_block;
	logic [LIMIT_W-1:0] shadow_limit;
	logic [DATA_W-1:0]  produced_total;
	logic [DATA_W-1:0]  consumed_total;
	logic [DATA_W-1:0]  dropped_total;
	queue_result_t      expected_ring [RING_DEPTH];
	int unsigned        ring_wr = 0;
	int unsigned        ring_rd = 0;
	queue_result_t      oldest_result;
	int unsigned        error_count = 0;

	assign mismatches = error_count;

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic predict_queue_op(input logic [1:0] op, input logic [DATA_W-1:0] word);
		queue_result_t r;
		int unsigned   lim;
		logic          full;
		lim = (shadow_limit == 0) ? 1 : ((shadow_limit > DEPTH) ? DEPTH : shadow_limit);
		full = shadow_count >= lim;
		r = '0;
		r.status = ST_DONE;
		case (op)
			OP_PUSH: begin
				if (shadow_block && !shadow_open) begin
					r.status = ST_CLOSED;
				end else if (full && shadow_block) begin
					r.status = ST_STALL;
				end else if (full) begin
					r.status = ST_DROPPED;
					dropped_total += (dropped_total != '1);
				end else begin
					shadow_store[(shadow_head + shadow_count) % DEPTH] = word;
					shadow_count++;
					produced_total += (produced_total != '1);
				end
			end
			OP_POP: begin
				if (shadow_count != 0) begin
					r.pop_value = shadow_store[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_count--;
					consumed_total += (consumed_total != '1);
				end else begin
					r.status = shadow_open ? ST_STALL : ST_CLOSED;
				end
			end
			OP_CLOSE: begin
				shadow_open = 1'b0;
			end
			default: begin
			end
		endcase
		r.occupancy = shadow_count[CNT_W-1:0];
		r.produced = produced_total;
		r.consumed = consumed_total;
		r.dropped = dropped_total;
		if (ring_wr - ring_rd >= RING_DEPTH) begin
			report_mismatch("too many results outstanding", ring_wr - ring_rd, '0);
		end else begin
			expected_ring[ring_wr % RING_DEPTH] = r;
			ring_wr++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_head = 0;
			shadow_count = 0;
			shadow_open = 1'b1;
			shadow_block = 1'b0;
			shadow_limit = LIMIT_RESET;
			produced_total = '0;
			consumed_total = '0;
			dropped_total = '0;
			ring_wr = 0;
			ring_rd = 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_QUEUE_LIMIT)
					shadow_limit = cfg_data[LIMIT_W-1:0];
				else
					shadow_block = cfg_data[0];
			end
			if (s_tvalid && s_tready)
				predict_queue_op(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (ring_wr == ring_rd) begin
					report_mismatch("transfer with no result expected", m_tdata[DATA_W-1:0], '0);
				end else begin
					oldest_result = expected_ring[ring_rd % RING_DEPTH];
					ring_rd++;
					if (m_tuser !== oldest_result.status)
						report_mismatch("status", m_tuser, oldest_result.status);
					if (m_tdata[DATA_W-1:0] !== oldest_result.pop_value)
						report_mismatch("pop_value", m_tdata[DATA_W-1:0],
							oldest_result.pop_value);
					if (m_tdata[OCC_LSB +: CNT_W] !== oldest_result.occupancy)
						report_mismatch("occupancy", m_tdata[OCC_LSB +: CNT_W],
							oldest_result.occupancy);
					if (m_tdata[PROD_LSB +: DATA_W] !== oldest_result.produced)
						report_mismatch("produced_count", m_tdata[PROD_LSB +: DATA_W],
							oldest_result.produced);
					if (m_tdata[CONS_LSB +: DATA_W] !== oldest_result.consumed)
						report_mismatch("consumed_count", m_tdata[CONS_LSB +: DATA_W],
							oldest_result.consumed);
					if (m_tdata[DROP_LSB +: DATA_W] !== oldest_result.dropped)
						report_mismatch("dropped_count", m_tdata[DROP_LSB +: DATA_W],
							oldest_result.dropped);
					if (m_tdata[OUT_TDATA_W-1:PAD_LSB] !== '0)
						report_mismatch("tdata pad", m_tdata[OUT_TDATA_W-1:PAD_LSB], '0);
				end
			end
			pending <= ring_wr - ring_rd;
		end
	end

endmodule

// ----- tb/bounded_fifo_with_drop_policy_core_tb.sv -----
// testbench top: stimulus, handshake pacing and verdict for the bounded fifo with drop policy
module bounded_fifo_with_drop_policy_core_tb;
	import bfwdp_pkg::*;

	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int SENDER_IDLE [4] = '{0, 75, 0, 26};
	localparam int RECEIVER_STALL [4] = '{0, 0, 75, 26};
	localparam int PHASE_LIMIT [10] = '{8, 1, 15, 4, 0, 2, 9, 6, 3, 7};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_QUEUE_LIMIT;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic [DATA_W-1:0]      s_tdata = '0;
	logic [1:0]             s_tuser = OP_PUSH;
	logic                   m_tready = 1'b0;
	wire                    s_tready;
	wire                    m_tvalid;
	wire [OUT_TDATA_W-1:0]  m_tdata;
	wire [1:0]              m_tuser;
	int unsigned            mismatches;
	int unsigned            pending;
	int unsigned            quiet_cycles = 0;
	int                     sender_idle_pct = 0;
	int                     stall_pct = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	bounded_fifo_with_drop_policy_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	fifo_result_checker result_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("bounded_fifo_with_drop_policy_core verification failed");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [DATA_W-1:0] word);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic run_traffic(input int count, input int push_pct);
		int         roll;
		logic [1:0] op;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < push_pct)
				op = OP_PUSH;
			else if (roll < push_pct + 3)
				op = OP_RESERVED;
			else
				op = OP_POP;
			send_item(op, $urandom);
		end
	endtask

	// drop valid and wait until every result has been taken
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_queue_config(input logic [LIMIT_W-1:0] limit, input logic mode);
		logic [CFG_W-2:0] spare;
		spare = $urandom;
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_QUEUE_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_index <= REG_BLOCK_MODE;
		cfg_data <= {spare, mode};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// open queue: empty pop, ignored code, data extremes
		set_queue_config(4'd8, 1'b0);
		send_item(OP_POP, '0);
		send_item(OP_RESERVED, 32'hFFFF_FFFF);
		send_item(OP_PUSH, 32'h7FFF_FFFF);
		send_item(OP_PUSH, 32'h8000_0000);
		send_item(OP_PUSH, 32'h0000_0000);
		send_item(OP_PUSH, 32'hFFFF_FFFF);
		repeat (5) send_item(OP_POP, $urandom);

		// zero limit acts as one: stall in block mode, drop in drop mode
		settle();
		set_queue_config(4'd0, 1'b1);
		send_item(OP_PUSH, 32'h5555_5555);
		send_item(OP_PUSH, 32'hAAAA_AAAA);
		send_item(OP_POP, '0);
		settle();
		set_queue_config(4'd0, 1'b0);
		send_item(OP_PUSH, 32'hAAAA_AAAA);
		send_item(OP_PUSH, 32'h5555_5555);
		send_item(OP_POP, '0);

		for (int p = 0; p < 10; p++) begin
			settle();
			sender_idle_pct = SENDER_IDLE[p % 4];
			stall_pct = RECEIVER_STALL[p % 4];
			set_queue_config(PHASE_LIMIT[p], p[0]);
			run_traffic(150, 40 + 10 * (p % 3));
		end

		// fill, close twice, then closed behavior in both modes
		settle();
		sender_idle_pct = SENDER_IDLE[3];
		stall_pct = RECEIVER_STALL[3];
		set_queue_config(4'd8, 1'b1);
		run_traffic(40, 75);
		send_item(OP_CLOSE, $urandom);
		send_item(OP_CLOSE, $urandom);
		send_item(OP_PUSH, $urandom);
		run_traffic(80, 30);
		settle();
		sender_idle_pct = SENDER_IDLE[2];
		stall_pct = RECEIVER_STALL[2];
		set_queue_config(4'd5, 1'b0);
		run_traffic(100, 50);

		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("bounded_fifo_with_drop_policy_core verification clean");
		else
			$display("bounded_fifo_with_drop_policy_core verification failed");
		$finish;
	end

endmodule
